FILE: rtl/core/hpx_pkg.sv
// Shared types, constants and the arctangent table of the HEALPix ring pixel pipeline.
package hpx_pkg;

  // Number of rotation cells and of square root cells.
  localparam int CORDIC_STEPS = 30;
  localparam int ROOT_STEPS   = 30;

  // Rotation word: signed Q30 with headroom.
  typedef logic signed [32:0] cw_t;
  // Square root word: radicand and partial root.
  typedef logic [59:0] rw_t;
  // Small signed integers of the pixel arithmetic.
  typedef logic signed [31:0] pint_t;

  // Fixed Q30 constants.
  localparam logic signed [35:0] PI_Q      = 36'sd3373259426;
  localparam logic signed [35:0] HALFPI_Q  = 36'sd1686629713;
  localparam logic signed [35:0] TWOPI_Q   = 36'sd6746518852;
  localparam logic signed [35:0] QONE_Q    = 36'sd1073741824;
  localparam logic signed [35:0] QHALF_Q   = 36'sd536870912;
  localparam logic [29:0]        INV_HPI_Q = 30'd683565275;
  localparam cw_t                TWOTHIRDS = 33'sd715827883;
  localparam cw_t                CORDIC_K  = 33'sd652032874;

  // floor(atan(2^-i) * 2^30).
  localparam cw_t ATAN_TAB [CORDIC_STEPS] = '{
    33'sd843314856, 33'sd497837829, 33'sd263043836, 33'sd133525158, 33'sd67021686,
    33'sd33543515, 33'sd16775850, 33'sd8388437, 33'sd4194282, 33'sd2097149,
    33'sd1048575, 33'sd524287, 33'sd262143, 33'sd131071, 33'sd65535,
    33'sd32767, 33'sd16383, 33'sd8191, 33'sd4095, 33'sd2047,
    33'sd1023, 33'sd511, 33'sd255, 33'sd127, 33'sd63,
    33'sd31, 33'sd15, 33'sd7, 33'sd3, 33'sd1
  };

  // Side data that rides along the rotation cells.
  typedef struct packed {
    logic        ok;
    logic        neg;
    logic [32:0] ph;
  } cside_t;

  // Side data that rides along the square root cells.
  typedef struct packed {
    logic        ok;
    logic        eq;
    cw_t         zv;
    logic [31:0] tt;
  } rside_t;

endpackage

FILE: rtl/core/hpx_cordic_cell.sv
// One rotation-mode CORDIC cell: a single micro-rotation followed by a register.
module hpx_cordic_cell
  import hpx_pkg::*;
#(
  parameter int STEP = 0
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_live,
  input  cw_t    in_x,
  input  cw_t    in_y,
  input  cw_t    in_z,
  input  cside_t in_side,
  output logic   out_live_r,
  output cw_t    out_x_r,
  output cw_t    out_y_r,
  output cw_t    out_z_r,
  output cside_t out_side_r
);

  cw_t x_nxt;
  cw_t y_nxt;
  cw_t z_nxt;

  // Rotate toward zero residual angle; shifts round toward minus infinity.
  always_comb begin
    if (!in_z[32]) begin
      x_nxt = in_x - (in_y >>> STEP);
      y_nxt = in_y + (in_x >>> STEP);
      z_nxt = in_z - ATAN_TAB[STEP];
    end else begin
      x_nxt = in_x + (in_y >>> STEP);
      y_nxt = in_y - (in_x >>> STEP);
      z_nxt = in_z + ATAN_TAB[STEP];
    end
  end

  // Occupancy flag is reset; the data words are not.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_live_r <= 1'b0;
    end else begin
      out_live_r <= in_live;
    end
  end

  always_ff @(posedge clk) begin
    out_x_r    <= x_nxt;
    out_y_r    <= y_nxt;
    out_z_r    <= z_nxt;
    out_side_r <= in_side;
  end

endmodule

FILE: rtl/core/hpx_sqrt_cell.sv
// One restoring square root cell: settles one root bit and registers the result.
module hpx_sqrt_cell
  import hpx_pkg::*;
#(
  parameter int STEP = 0
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_live,
  input  rw_t    in_v,
  input  rw_t    in_r,
  input  rside_t in_side,
  output logic   out_live_r,
  output rw_t    out_v_r,
  output rw_t    out_r_r,
  output rside_t out_side_r
);

  localparam rw_t BIT = rw_t'(1) << (58 - 2 * STEP);

  rw_t trial;
  rw_t v_nxt;
  rw_t r_nxt;

  // Subtract the trial value when it fits and set the matching root bit.
  always_comb begin
    trial = in_r + BIT;
    if (in_v >= trial) begin
      v_nxt = in_v - trial;
      r_nxt = (in_r >> 1) + BIT;
    end else begin
      v_nxt = in_v;
      r_nxt = in_r >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_live_r <= 1'b0;
    end else begin
      out_live_r <= in_live;
    end
  end

  always_ff @(posedge clk) begin
    out_v_r    <= v_nxt;
    out_r_r    <= r_nxt;
    out_side_r <= in_side;
  end

endmodule

FILE: rtl/core/healpix_ang2pix_ring_top.sv
// Top level of the HEALPix angle to RING pixel pipeline.
// Takes one word per clock and never asserts busy. Every word gives one result word
// once it has passed one input stage, 30 CORDIC cells for cos(theta), one
// stage that forms z and phi/(pi/2), 30 square root cells for the polar caps, and four
// stages of pixel arithmetic. Results appear for one cycle under out_strobe and must be
// taken then. Colatitude outside 0..pi gives out_valid_res low and a pixel index of 0.
module healpix_ang2pix_ring_top
  import hpx_pkg::*;
#(
  parameter int SIDE_RES = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic signed [18:0]  in_colatitude,
  input  logic signed [20:0]  in_longitude,
  output logic                out_strobe,
  output logic [15:0]         out_pixel_index,
  output logic                out_valid_res
);

  localparam pint_t NS       = 32'(SIDE_RES);
  localparam pint_t NPIX     = 32'(12 * SIDE_RES * SIDE_RES);
  localparam pint_t EQ_BASE  = 32'(2 * SIDE_RES * (SIDE_RES - 1));
  localparam int    LATENCY  = CORDIC_STEPS + ROOT_STEPS + 6;

  // The pipeline takes a word every cycle.
  assign busy = 1'b0;

  // ---------------------------------------------------------------- input stage
  logic signed [35:0] th;
  logic signed [35:0] ph0;
  logic signed [35:0] ph1;
  logic signed [35:0] ph2;
  logic signed [35:0] ph3;
  logic signed [35:0] ang;
  logic               s0_live_r;
  cw_t                s0_ang_r;
  cside_t             s0_side_r;

  // Fold theta into 0..pi/2 and wrap phi once into one turn.
  always_comb begin
    th  = 36'(in_colatitude) <<< 14;
    ang = (th > HALFPI_Q) ? (PI_Q - th) : th;
    ph0 = 36'(in_longitude) <<< 14;
    ph1 = (ph0 >= TWOPI_Q) ? (ph0 - TWOPI_Q) : ph0;
    ph2 = (ph1 < 0) ? (ph1 + TWOPI_Q) : ph1;
    if (ph2 < 0) begin
      ph3 = '0;
    end else if (ph2 >= TWOPI_Q) begin
      ph3 = TWOPI_Q - 36'sd1;
    end else begin
      ph3 = ph2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_live_r <= 1'b0;
    end else begin
      s0_live_r <= start;
    end
  end

  always_ff @(posedge clk) begin
    s0_ang_r       <= 33'(ang);
    s0_side_r.ok   <= (th >= 0) && (th <= PI_Q);
    s0_side_r.neg  <= th > HALFPI_Q;
    s0_side_r.ph   <= ph3[32:0];
  end

  // ---------------------------------------------------------------- CORDIC row
  logic   c_live [CORDIC_STEPS + 1];
  cw_t    c_x    [CORDIC_STEPS + 1];
  cw_t    c_y    [CORDIC_STEPS + 1];
  cw_t    c_z    [CORDIC_STEPS + 1];
  cside_t c_side [CORDIC_STEPS + 1];

  assign c_live[0] = s0_live_r;
  assign c_x[0]    = CORDIC_K;
  assign c_y[0]    = '0;
  assign c_z[0]    = s0_ang_r;
  assign c_side[0] = s0_side_r;

  for (genvar gi = 0; gi < CORDIC_STEPS; gi++) begin : g_cordic
    hpx_cordic_cell #(.STEP(gi)) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .in_live    (c_live[gi]),
      .in_x       (c_x[gi]),
      .in_y       (c_y[gi]),
      .in_z       (c_z[gi]),
      .in_side    (c_side[gi]),
      .out_live_r (c_live[gi + 1]),
      .out_x_r    (c_x[gi + 1]),
      .out_y_r    (c_y[gi + 1]),
      .out_z_r    (c_z[gi + 1]),
      .out_side_r (c_side[gi + 1])
    );
  end

  // ---------------------------------------------------------------- z and tt stage
  cw_t                zv;
  cw_t                za;
  logic signed [35:0] wv;
  logic [29:0]        wc;
  logic [62:0]        tt_prod;
  logic               p1_live_r;
  rw_t                p1_v_r;
  rside_t             p1_side_r;

  // Sign z by hemisphere, build the clamped radicand and scale phi by 2/pi.
  always_comb begin
    zv = c_side[CORDIC_STEPS].neg ? -c_x[CORDIC_STEPS] : c_x[CORDIC_STEPS];
    za = zv[32] ? -zv : zv;
    wv = 36'sd3 * (QONE_Q - 36'(za));
    if (wv < 0) begin
      wc = '0;
    end else if (wv >= QONE_Q) begin
      wc = '1;
    end else begin
      wc = wv[29:0];
    end
    tt_prod = 63'(c_side[CORDIC_STEPS].ph) * 63'(INV_HPI_Q);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_live_r <= 1'b0;
    end else begin
      p1_live_r <= c_live[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    p1_v_r       <= {wc, 30'd0};
    p1_side_r.ok <= c_side[CORDIC_STEPS].ok;
    p1_side_r.eq <= za <= TWOTHIRDS;
    p1_side_r.zv <= zv;
    p1_side_r.tt <= tt_prod[61:30];
  end

  // ---------------------------------------------------------------- square root row
  logic   r_live [ROOT_STEPS + 1];
  rw_t    r_v    [ROOT_STEPS + 1];
  rw_t    r_r    [ROOT_STEPS + 1];
  rside_t r_side [ROOT_STEPS + 1];

  assign r_live[0] = p1_live_r;
  assign r_v[0]    = p1_v_r;
  assign r_r[0]    = '0;
  assign r_side[0] = p1_side_r;

  for (genvar gk = 0; gk < ROOT_STEPS; gk++) begin : g_root
    hpx_sqrt_cell #(.STEP(gk)) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .in_live    (r_live[gk]),
      .in_v       (r_v[gk]),
      .in_r       (r_r[gk]),
      .in_side    (r_side[gk]),
      .out_live_r (r_live[gk + 1]),
      .out_v_r    (r_v[gk + 1]),
      .out_r_r    (r_r[gk + 1]),
      .out_side_r (r_side[gk + 1])
    );
  end

  // ---------------------------------------------------------------- stage F1
  rside_t             rs;
  logic [29:0]        rt;
  logic [29:0]        tp;
  logic signed [35:0] q;
  logic signed [35:0] se_p;
  logic signed [35:0] se_m;
  logic signed [47:0] me_p;
  logic signed [47:0] me_m;
  logic [59:0]        pa_prod;
  logic [60:0]        pb_prod;
  logic               f1_live_r;
  logic               f1_ok_r;
  logic               f1_eq_r;
  logic               f1_zle_r;
  logic [31:0]        f1_tt_r;
  pint_t              f1_jp_r;
  pint_t              f1_jm_r;
  logic [29:0]        f1_pa_r;
  logic [30:0]        f1_pb_r;

  // Equatorial edge lines scaled by side; polar fractions times the root.
  always_comb begin
    rs      = r_side[ROOT_STEPS];
    rt      = r_r[ROOT_STEPS][29:0];
    tp      = rs.tt[29:0];
    q       = (36'sd3 * 36'(rs.zv)) >>> 2;
    se_p    = QHALF_Q + $signed({4'd0, rs.tt}) - q;
    se_m    = QHALF_Q + $signed({4'd0, rs.tt}) + q;
    me_p    = 48'(se_p) * 48'(NS);
    me_m    = 48'(se_m) * 48'(NS);
    pa_prod = 60'(tp) * 60'(rt);
    pb_prod = 61'(31'(QONE_Q) - 31'(tp)) * 61'(rt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_live_r <= 1'b0;
    end else begin
      f1_live_r <= r_live[ROOT_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    f1_ok_r  <= rs.ok;
    f1_eq_r  <= rs.eq;
    f1_zle_r <= rs.zv <= 0;
    f1_tt_r  <= rs.tt;
    f1_jp_r  <= 32'(me_p >>> 30);
    f1_jm_r  <= me_m[47] ? '0 : 32'(me_m >>> 30);
    f1_pa_r  <= pa_prod[59:30];
    f1_pb_r  <= pb_prod[60:30];
  end

  // ---------------------------------------------------------------- stage F2
  pint_t       ir_e;
  pint_t       num;
  pint_t       half;
  pint_t       ip_e;
  logic [47:0] jpp_prod;
  logic [47:0] jmp_prod;
  pint_t       ir_p;
  logic        f2_live_r;
  logic        f2_ok_r;
  logic        f2_eq_r;
  logic        f2_zle_r;
  logic [31:0] f2_tt_r;
  pint_t       f2_ir_e_r;
  pint_t       f2_ip_e_r;
  pint_t       f2_ir_p_r;

  // Ring and in-ring index on the equator; ring number in the caps.
  always_comb begin
    ir_e = NS + 32'sd1 + f1_jp_r - f1_jm_r;
    num  = f1_jp_r + f1_jm_r - NS + (ir_e[0] ? 32'sd0 : 32'sd1) + 32'sd1;
    half = (num >>> 1) + ((num < 0 && num[0]) ? 32'sd1 : 32'sd0);
    ip_e = half + 32'sd1;
    if (ip_e > 32'sd4 * NS) begin
      ip_e = ip_e - 32'sd4 * NS;
    end
    jpp_prod = 48'(f1_pa_r) * 48'(SIDE_RES);
    jmp_prod = 48'(f1_pb_r) * 48'(SIDE_RES);
    ir_p     = 32'(jpp_prod >> 30) + 32'(jmp_prod >> 30) + 32'sd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f2_live_r <= 1'b0;
    end else begin
      f2_live_r <= f1_live_r;
    end
  end

  always_ff @(posedge clk) begin
    f2_ok_r   <= f1_ok_r;
    f2_eq_r   <= f1_eq_r;
    f2_zle_r  <= f1_zle_r;
    f2_tt_r   <= f1_tt_r;
    f2_ir_e_r <= ir_e;
    f2_ip_e_r <= ip_e;
    f2_ir_p_r <= ir_p;
  end

  // ---------------------------------------------------------------- stage F3
  pint_t       pix_e;
  logic [47:0] ipt_prod;
  pint_t       ipt;
  logic        f3_live_r;
  logic        f3_ok_r;
  logic        f3_eq_r;
  logic        f3_zle_r;
  pint_t       f3_pix_e_r;
  pint_t       f3_ipt_r;
  pint_t       f3_pn_r;
  pint_t       f3_ps_r;

  // Equatorial pixel; polar in-ring index and ring offsets.
  always_comb begin
    pix_e    = EQ_BASE + 32'sd4 * NS * (f2_ir_e_r - 32'sd1) + f2_ip_e_r;
    ipt_prod = 48'(f2_tt_r) * 48'(f2_ir_p_r[15:0]);
    ipt      = 32'(ipt_prod >> 30) + 32'sd1;
    if (ipt > 32'sd4 * f2_ir_p_r) begin
      ipt = ipt - 32'sd4 * f2_ir_p_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f3_live_r <= 1'b0;
    end else begin
      f3_live_r <= f2_live_r;
    end
  end

  always_ff @(posedge clk) begin
    f3_ok_r    <= f2_ok_r;
    f3_eq_r    <= f2_eq_r;
    f3_zle_r   <= f2_zle_r;
    f3_pix_e_r <= pix_e;
    f3_ipt_r   <= ipt;
    f3_pn_r    <= f2_ir_p_r * (f2_ir_p_r + 32'sd1);
    f3_ps_r    <= f2_ir_p_r * (f2_ir_p_r - 32'sd1);
  end

  // ---------------------------------------------------------------- output stage
  pint_t pix;
  logic  strobe_r;
  logic  valid_r;
  logic [15:0] index_r;

  // Pick the region, step to zero-based numbering and clamp to the map.
  always_comb begin
    if (f3_eq_r) begin
      pix = f3_pix_e_r;
    end else if (f3_zle_r) begin
      pix = NPIX - 32'sd2 * f3_pn_r + f3_ipt_r;
    end else begin
      pix = 32'sd2 * f3_ps_r + f3_ipt_r;
    end
    pix = pix - 32'sd1;
    if (pix < 0) begin
      pix = '0;
    end else if (pix > NPIX - 32'sd1) begin
      pix = NPIX - 32'sd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
      valid_r  <= 1'b0;
    end else begin
      strobe_r <= f3_live_r;
      valid_r  <= f3_live_r && f3_ok_r;
    end
  end

  always_ff @(posedge clk) begin
    index_r <= f3_ok_r ? pix[15:0] : 16'd0;
  end

  assign out_strobe      = strobe_r;
  assign out_valid_res   = valid_r;
  assign out_pixel_index = index_r;

`ifndef SYNTHESIS
  // Every accepted word comes out after the fixed pipeline depth.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> ##LATENCY out_strobe)
    else $error("result word missing after pipeline latency");

  // A valid flag is only shown together with the strobe.
  a_valid_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_res |-> out_strobe)
    else $error("valid result without strobe");

  // Out-of-range colatitude gives a zero index.
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_valid_res) |-> (out_pixel_index == 16'd0))
    else $error("invalid result with nonzero index");

  // A strobe needs a word in the last arithmetic stage in the cycle before.
  a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_strobe) |-> $past(f3_live_r))
    else $error("strobe without a word in flight");
`endif

endmodule
